/* rtl/core/lsae_pkg.sv */
// lsae_pkg: shared types, constants and helper functions of the led strip animation engine
// no dependencies; used by every other file of the block
package lsae_pkg;

  localparam int unsigned PIXELS = 32;
  localparam int unsigned PIX_W  = $clog2(PIXELS);
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned STREAMS = 4;

  typedef logic [PIX_W-1:0] pix_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_OFF   = 2'd2,
    CMD_ON    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_ROLL   = 3'd0,
    MODE_SOLID  = 3'd1,
    MODE_FOLLOW = 3'd2,
    MODE_GLOW   = 3'd3,
    MODE_CUSTOM = 3'd4,
    MODE_LAVA   = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_FOLLOW = 3'd1,
    REG_RED    = 3'd2,
    REG_GREEN  = 3'd3,
    REG_BLUE   = 3'd4
  } reg_e;

  // what one frame pass does to each pixel
  typedef enum logic [2:0] {
    OP_KEEP,
    OP_ROLL,
    OP_FILL,
    OP_FOLLOW,
    OP_LAVA
  } op_e;

  typedef struct packed {
    op_e                      kind;
    pix_idx_t                 head;
    pixel_t                   color;
    pixel_t                   dim;
    logic [7:0]               follow_len;
    logic [STREAMS-1:0]       lava_on;
    pix_idx_t [STREAMS-1:0]   lava_cur;
    pix_idx_t [STREAMS-1:0]   lava_prev;
  } frame_op_t;

  // stream 0 has three pixels, the others two
  function automatic logic [1:0] lava_len(logic [1:0] s);
    return (s == 2'd0) ? 2'd3 : 2'd2;
  endfunction

  function automatic pix_idx_t lava_pixel(logic [1:0] s, logic [1:0] pos);
    case ({s, pos})
      4'b00_00: return pix_idx_t'(0);
      4'b00_01: return pix_idx_t'(1);
      4'b00_10: return pix_idx_t'(2);
      4'b01_00: return pix_idx_t'(4);
      4'b01_01: return pix_idx_t'(3);
      4'b10_00: return pix_idx_t'(5);
      4'b10_01: return pix_idx_t'(6);
      4'b11_00: return pix_idx_t'(8);
      4'b11_01: return pix_idx_t'(9);
      default:  return pix_idx_t'(0);
    endcase
  endfunction

  // x / 3 for 8-bit x by reciprocal multiply, exact over the full range
  function automatic logic [CH_W-1:0] div3(logic [CH_W-1:0] x);
    logic [16:0] prod;
    prod = 17'(x) * 17'd171;
    return prod[16:9];
  endfunction

endpackage

/* rtl/core/lsae_if.sv */
// lsae_in_if / lsae_out_if: valid/ready channels carrying command and pixel items
// depends on lsae_pkg for field widths
interface lsae_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  cmd;
  logic [lsae_pkg::IDX_W-1:0]  pixel_index;
  logic [lsae_pkg::CH_W-1:0]   pixel_red;
  logic [lsae_pkg::CH_W-1:0]   pixel_green;
  logic [lsae_pkg::CH_W-1:0]   pixel_blue;

  modport source (output valid, cmd, pixel_index, pixel_red, pixel_green, pixel_blue,
                  input ready);
  modport sink (input valid, cmd, pixel_index, pixel_red, pixel_green, pixel_blue,
                output ready);
endinterface

interface lsae_out_if;
  logic                        valid;
  logic                        ready;
  logic [lsae_pkg::IDX_W-1:0]  out_index;
  logic [lsae_pkg::CH_W-1:0]   out_red;
  logic [lsae_pkg::CH_W-1:0]   out_green;
  logic [lsae_pkg::CH_W-1:0]   out_blue;
  logic                        frame_end;

  modport source (output valid, out_index, out_red, out_green, out_blue, frame_end,
                  input ready);
  modport sink (input valid, out_index, out_red, out_green, out_blue, frame_end,
                output ready);
endinterface

/* rtl/core/led_strip_animation_engine_core.sv */
// led_strip_animation_engine_core: top level of the pixel strip pattern generator
// depends on lsae_pkg, lsae_if, lsae_store and lsae_shade
// a tick sweeps the frame store once by read-modify-write: each pixel is read, reshaded, written
// back and queued, then shown one pixel per cycle while the output does not stall; no next item is
// taken until the last read is back; write, off and on items use one store port each way
// async active-low reset; the store reads black at once through per-entry valid bits
module led_strip_animation_engine_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  lsae_in_if.sink                  in_i,
  lsae_out_if.source               out_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int unsigned PW = lsae_pkg::PIX_W;

  typedef struct packed {
    lsae_pkg::pix_idx_t idx;
    lsae_pkg::pixel_t   px;
    logic               last;
  } out_item_t;

  // configuration registers
  logic [2:0]          mode_q, mode_d;
  logic [7:0]          follow_len_q, follow_len_d;
  lsae_pkg::pixel_t    base_q, base_d;

  // animation state
  logic                hold_q, hold_d;
  logic                enabled_q, enabled_d;
  logic [3:0]          ph10_q, ph10_d;
  logic [4:0]          ph20_q, ph20_d;
  logic [4:0]          ph21_q, ph21_d;
  logic [4:0]          ph31_q, ph31_d;
  logic [5:0]          ph43_q, ph43_d;
  lsae_pkg::pix_idx_t  head_q, head_d;
  logic [1:0]          roll_q, roll_d;
  logic [7:0]          glow_q, glow_d;
  logic                falling_q, falling_d;
  logic [1:0]          spos_q [lsae_pkg::STREAMS];
  logic [1:0]          spos_d [lsae_pkg::STREAMS];
  lsae_pkg::frame_op_t op_q, op_d;

  // sweep and output queue
  logic                issuing_q, issuing_d;
  lsae_pkg::pix_idx_t  rd_idx_q, rd_idx_d;
  logic                rvalid_q;
  lsae_pkg::pix_idx_t  raddr_q;
  out_item_t           ent_q [2];
  out_item_t           ent_d [2];
  logic [1:0]          cnt_q, cnt_d;

  logic                in_acc, tick_acc, pix_wr, cfg_wr;
  logic                pop, issue;
  logic [1:0]          occ;
  lsae_pkg::pixel_t    rdata, shaded;
  logic                mem_we;
  lsae_pkg::pix_idx_t  mem_waddr;
  lsae_pkg::pixel_t    mem_wdata;
  out_item_t           push_item;

  // tick helpers
  logic [3:0]          ph10_n;
  logic [4:0]          ph20_n, ph21_n, ph31_n;
  logic [5:0]          ph43_n;
  logic                tenth;
  logic [PW:0]         head_inc;
  lsae_pkg::pix_idx_t  head_adv;
  logic [1:0]          roll_adv;
  logic [8:0]          glow_sum;
  logic [7:0]          glow_n;
  logic                falling_n;
  logic [2:0]          eff_mode;
  logic [lsae_pkg::STREAMS-1:0] lava_step;
  logic [1:0]          s_len, s_prev, s_next;

  function automatic lsae_pkg::pixel_t roll_colour(logic [1:0] ph);
    case (ph)
      2'd0:    return '{red: 8'hFF, green: 8'h00, blue: 8'h00};
      2'd1:    return '{red: 8'h00, green: 8'hFF, blue: 8'h00};
      default: return '{red: 8'h00, green: 8'h00, blue: 8'hFF};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  assign in_i.ready = !issuing_q && !rvalid_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign tick_acc   = in_acc && (in_i.cmd == lsae_pkg::CMD_TICK);
  assign pix_wr     = in_acc && (in_i.cmd == lsae_pkg::CMD_WRITE) &&
                      ({1'b0, in_i.pixel_index} < (lsae_pkg::IDX_W+1)'(lsae_pkg::PIXELS));

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register read-back
  always_comb begin
    case (paddr[4:2])
      lsae_pkg::REG_MODE:   prdata = 32'(mode_q);
      lsae_pkg::REG_FOLLOW: prdata = 32'(follow_len_q);
      lsae_pkg::REG_RED:    prdata = 32'(base_q.red);
      lsae_pkg::REG_GREEN:  prdata = 32'(base_q.green);
      lsae_pkg::REG_BLUE:   prdata = 32'(base_q.blue);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // per-tick updates: phases, head, glow, lava streams
  // ---------------------------------------------------------------------------
  always_comb begin
    // phases wrap at their periods
    ph10_n = (ph10_q == 4'd9)  ? '0 : ph10_q + 4'd1;
    ph20_n = (ph20_q == 5'd19) ? '0 : ph20_q + 5'd1;
    ph21_n = (ph21_q == 5'd20) ? '0 : ph21_q + 5'd1;
    ph31_n = (ph31_q == 5'd30) ? '0 : ph31_q + 5'd1;
    ph43_n = (ph43_q == 6'd42) ? '0 : ph43_q + 6'd1;
    tenth  = (ph10_n == '0);
    lava_step = {ph43_n == '0, ph31_n == '0, ph21_n == '0, ph20_n == '0};

    // head step with colour phase on the wrap
    head_inc = {1'b0, head_q} + (PW+1)'(1);
    if (head_inc >= (PW+1)'(lsae_pkg::PIXELS)) begin
      head_adv = '0;
      roll_adv = (roll_q == 2'd2) ? 2'd0 : roll_q + 2'd1;
    end else begin
      head_adv = head_inc[PW-1:0];
      roll_adv = roll_q;
    end

    // glow triangle, turning at the top and at zero
    glow_sum = {1'b0, glow_q} + 9'd10;
    if (!falling_q) begin
      if (glow_sum >= 9'd254) begin
        glow_n    = 8'd255;
        falling_n = 1'b1;
      end else begin
        glow_n    = glow_sum[7:0];
        falling_n = 1'b0;
      end
    end else begin
      if (glow_q <= 8'd10) begin
        glow_n    = 8'd0;
        falling_n = 1'b0;
      end else begin
        glow_n    = glow_q - 8'd10;
        falling_n = 1'b1;
      end
    end

    eff_mode = hold_q ? 3'(lsae_pkg::MODE_CUSTOM) : mode_q;
  end

  always_comb begin
    ph10_d    = ph10_q;
    ph20_d    = ph20_q;
    ph21_d    = ph21_q;
    ph31_d    = ph31_q;
    ph43_d    = ph43_q;
    head_d    = head_q;
    roll_d    = roll_q;
    glow_d    = glow_q;
    falling_d = falling_q;
    spos_d    = spos_q;
    op_d      = op_q;
    s_len     = 2'd0;
    s_prev    = 2'd0;
    s_next    = 2'd0;

    if (tick_acc) begin
      ph10_d = ph10_n;
      ph20_d = ph20_n;
      ph21_d = ph21_n;
      ph31_d = ph31_n;
      ph43_d = ph43_n;

      op_d            = '0;
      op_d.kind       = lsae_pkg::OP_KEEP;
      op_d.follow_len = follow_len_q;
      op_d.color      = base_q;
      op_d.dim        = '{red:   lsae_pkg::div3(base_q.red),
                          green: lsae_pkg::div3(base_q.green),
                          blue:  lsae_pkg::div3(base_q.blue)};
      op_d.head       = head_q;

      // with the strip off the pass only streams the store out
      if (enabled_q) begin
        case (eff_mode)
          lsae_pkg::MODE_ROLL: begin
            if (tenth) begin
              head_d       = head_adv;
              roll_d       = roll_adv;
              op_d.kind    = lsae_pkg::OP_ROLL;
              op_d.head    = head_adv;
              op_d.color   = roll_colour(roll_adv);
            end
          end
          lsae_pkg::MODE_SOLID: begin
            op_d.kind = lsae_pkg::OP_FILL;
          end
          lsae_pkg::MODE_FOLLOW: begin
            if (tenth) begin
              head_d    = head_adv;
              roll_d    = roll_adv;
              op_d.kind = lsae_pkg::OP_FOLLOW;
              op_d.head = head_adv;
            end
          end
          lsae_pkg::MODE_GLOW: begin
            if (tenth) begin
              glow_d     = glow_n;
              falling_d  = falling_n;
              op_d.kind  = lsae_pkg::OP_FILL;
              op_d.color = '{red: glow_n, green: 8'h00, blue: 8'h00};
            end
          end
          lsae_pkg::MODE_LAVA: begin
            op_d.kind    = lsae_pkg::OP_LAVA;
            op_d.lava_on = lava_step;
            for (int s = 0; s < lsae_pkg::STREAMS; s++) begin
              s_len  = lsae_pkg::lava_len(2'(s));
              s_prev = (spos_q[s] == 2'd0) ? s_len - 2'd1 : spos_q[s] - 2'd1;
              s_next = (spos_q[s] == s_len - 2'd1) ? 2'd0 : spos_q[s] + 2'd1;
              op_d.lava_cur[s]  = lsae_pkg::lava_pixel(2'(s), spos_q[s]);
              op_d.lava_prev[s] = lsae_pkg::lava_pixel(2'(s), s_prev);
              if (lava_step[s]) begin
                spos_d[s] = s_next;
              end
            end
          end
          default: begin
            op_d.kind = lsae_pkg::OP_KEEP;
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // configuration, enable and manual hold
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_d       = mode_q;
    follow_len_d = follow_len_q;
    base_d       = base_q;
    hold_d       = hold_q;
    enabled_d    = enabled_q;

    if (cfg_wr) begin
      case (paddr[4:2])
        lsae_pkg::REG_MODE: begin
          mode_d = pwdata[2:0];
          hold_d = 1'b0;
        end
        lsae_pkg::REG_FOLLOW: follow_len_d = pwdata[7:0];
        lsae_pkg::REG_RED:    base_d.red   = pwdata[7:0];
        lsae_pkg::REG_GREEN:  base_d.green = pwdata[7:0];
        lsae_pkg::REG_BLUE:   base_d.blue  = pwdata[7:0];
        default: ;
      endcase
    end

    if (in_acc) begin
      case (in_i.cmd)
        lsae_pkg::CMD_WRITE: hold_d    = 1'b1;  // out-of-range writes hold too
        lsae_pkg::CMD_OFF:   enabled_d = 1'b0;
        lsae_pkg::CMD_ON:    enabled_d = 1'b1;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // store sweep: read pixel, reshade, write back and queue for output
  // ---------------------------------------------------------------------------
  assign pop = out_o.valid && out_o.ready;
  assign occ = cnt_q + {1'b0, rvalid_q};
  // a read is issued only when its pixel is sure of a queue slot
  assign issue = issuing_q && ((occ < 2'd2) || (occ == 2'd2 && pop));

  always_comb begin
    issuing_d = issuing_q;
    rd_idx_d  = rd_idx_q;
    if (tick_acc) begin
      issuing_d = 1'b1;
      rd_idx_d  = '0;
    end else if (issue) begin
      rd_idx_d = rd_idx_q + PW'(1);
      if (rd_idx_q == PW'(lsae_pkg::PIXELS - 1)) begin
        issuing_d = 1'b0;
      end
    end
  end

  lsae_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (in_acc && (in_i.cmd == lsae_pkg::CMD_OFF)),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  lsae_shade u_shade (
    .op_i  (op_q),
    .idx_i (raddr_q),
    .old_i (rdata),
    .new_o (shaded)
  );

  // write-back of the sweep has the port; pixel writes come only while idle
  always_comb begin
    mem_we    = rvalid_q || pix_wr;
    mem_waddr = rvalid_q ? raddr_q : in_i.pixel_index[PW-1:0];
    mem_wdata = rvalid_q ? shaded
                         : '{red: in_i.pixel_red, green: in_i.pixel_green,
                             blue: in_i.pixel_blue};
  end

  // two-entry output queue
  always_comb begin
    push_item.idx  = raddr_q;
    push_item.px   = shaded;
    push_item.last = (raddr_q == PW'(lsae_pkg::PIXELS - 1));

    ent_d = ent_q;
    cnt_d = cnt_q;
    if (pop) begin
      ent_d[0] = ent_q[1];
    end
    if (rvalid_q) begin
      if (pop) begin
        ent_d[cnt_q == 2'd2 ? 1 : 0] = push_item;
      end else begin
        ent_d[cnt_q == 2'd0 ? 0 : 1] = push_item;
      end
    end
    cnt_d = cnt_q + {1'b0, rvalid_q} - {1'b0, pop};
  end

  assign out_o.valid     = (cnt_q != 2'd0);
  assign out_o.out_index = lsae_pkg::IDX_W'(ent_q[0].idx);
  assign out_o.out_red   = ent_q[0].px.red;
  assign out_o.out_green = ent_q[0].px.green;
  assign out_o.out_blue  = ent_q[0].px.blue;
  assign out_o.frame_end = ent_q[0].last;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 3'(lsae_pkg::MODE_ROLL);
      follow_len_q <= 8'd5;
      base_q       <= '{red: 8'hFF, green: 8'h00, blue: 8'h00};
      hold_q       <= 1'b0;
      enabled_q    <= 1'b1;
      ph10_q       <= '0;
      ph20_q       <= '0;
      ph21_q       <= '0;
      ph31_q       <= '0;
      ph43_q       <= '0;
      head_q       <= '0;
      roll_q       <= '0;
      glow_q       <= '0;
      falling_q    <= 1'b0;
      for (int s = 0; s < lsae_pkg::STREAMS; s++) begin
        spos_q[s] <= '0;
      end
      issuing_q    <= 1'b0;
      rd_idx_q     <= '0;
      rvalid_q     <= 1'b0;
      cnt_q        <= '0;
    end else begin
      mode_q       <= mode_d;
      follow_len_q <= follow_len_d;
      base_q       <= base_d;
      hold_q       <= hold_d;
      enabled_q    <= enabled_d;
      ph10_q       <= ph10_d;
      ph20_q       <= ph20_d;
      ph21_q       <= ph21_d;
      ph31_q       <= ph31_d;
      ph43_q       <= ph43_d;
      head_q       <= head_d;
      roll_q       <= roll_d;
      glow_q       <= glow_d;
      falling_q    <= falling_d;
      spos_q       <= spos_d;
      issuing_q    <= issuing_d;
      rd_idx_q     <= rd_idx_d;
      rvalid_q     <= issue;
      cnt_q        <= cnt_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    raddr_q <= rd_idx_q;
    ent_q   <= ent_d;
  end

endmodule

/* rtl/core/lsae_store.sv */
// lsae_store: frame store memory, one write and one registered read port per cycle
// depends on lsae_pkg; entries never written since reset or clear read as black
module lsae_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  logic              we_i,
  input  lsae_pkg::pix_idx_t waddr_i,
  input  lsae_pkg::pixel_t  wdata_i,
  input  logic              re_i,
  input  lsae_pkg::pix_idx_t raddr_i,
  output lsae_pkg::pixel_t  rdata_o
);

  lsae_pkg::pixel_t                mem_q [lsae_pkg::PIXELS];
  logic [lsae_pkg::PIXELS-1:0]     vld_q;
  lsae_pkg::pixel_t                rd_q;
  logic                            rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  // per-entry valid bits stand in for clearing the array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

/* rtl/core/lsae_shade.sv */
// lsae_shade: new colour of one pixel from its old colour and the frame operation
// depends on lsae_pkg (frame_op_t, pixel_t)
module lsae_shade (
  input  lsae_pkg::frame_op_t op_i,
  input  lsae_pkg::pix_idx_t  idx_i,
  input  lsae_pkg::pixel_t    old_i,
  output lsae_pkg::pixel_t    new_o
);

  logic [lsae_pkg::PIX_W:0] span_raw;
  lsae_pkg::pix_idx_t       span;

  // distance from the head up to this pixel, wrapped around the strip
  always_comb begin
    span_raw = {1'b0, idx_i} + (lsae_pkg::PIX_W+1)'(lsae_pkg::PIXELS) - {1'b0, op_i.head};
    if (span_raw >= (lsae_pkg::PIX_W+1)'(lsae_pkg::PIXELS)) begin
      span_raw = span_raw - (lsae_pkg::PIX_W+1)'(lsae_pkg::PIXELS);
    end
    span = span_raw[lsae_pkg::PIX_W-1:0];
  end

  always_comb begin
    new_o = old_i;
    case (op_i.kind)
      lsae_pkg::OP_ROLL: begin
        if (idx_i == op_i.head) begin
          new_o = op_i.color;
        end
      end
      lsae_pkg::OP_FILL: begin
        new_o = op_i.color;
      end
      lsae_pkg::OP_FOLLOW: begin
        new_o = (8'(span) <= op_i.follow_len) ? op_i.color : '0;
      end
      lsae_pkg::OP_LAVA: begin
        // stream pixel sets are disjoint, so the order does not matter
        for (int s = 0; s < lsae_pkg::STREAMS; s++) begin
          if (op_i.lava_on[s] && idx_i == op_i.lava_cur[s]) begin
            new_o = op_i.color;
          end
          if (op_i.lava_on[s] && idx_i == op_i.lava_prev[s]) begin
            new_o = op_i.dim;
          end
        end
      end
      default: begin
        new_o = old_i;
      end
    endcase
  end

endmodule

/* rtl/core/lsae_chk.sv */
// lsae_chk: port-level checks of the animation engine over time, bound to the top level
// depends on lsae_pkg and led_strip_animation_engine_core
module lsae_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  in_cmd,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lsae_pkg::IDX_W-1:0]  out_index,
  input logic                        out_frame_end
);

  logic [lsae_pkg::IDX_W-1:0] exp_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (out_valid && out_ready) begin
      exp_idx_q <= out_frame_end ? '0 : exp_idx_q + lsae_pkg::IDX_W'(1);
    end
  end

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_frame_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_frame_end |-> out_index == lsae_pkg::IDX_W'(lsae_pkg::PIXELS - 1))
    else $error("frame end flagged on a pixel other than the last");

  a_index_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready |-> out_index == exp_idx_q)
    else $error("pixels not streamed in order");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_cmd == lsae_pkg::CMD_TICK |=> !in_ready)
    else $error("new item taken while a frame sweep runs");

endmodule

bind led_strip_animation_engine_core lsae_chk u_lsae_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .in_cmd        (in_i.cmd),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .out_index     (out_o.out_index),
  .out_frame_end (out_o.frame_end)
);
